FILE: design/stack_pop_sequence_checker_defines.svh
// ----------------------------------------------------------------------------
// Stack pop sequence checker assertion macros
// Shared assertion forms for the checker blocks.
// ----------------------------------------------------------------------------
`ifndef STACK_POP_SEQUENCE_CHECKER_DEFINES_SVH
`define STACK_POP_SEQUENCE_CHECKER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SPSC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stack pop sequence check failed");

// next-cycle implication, disabled in reset
`define SPSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stack pop sequence check failed");

`endif

FILE: design/spsc_pkg.sv
// ----------------------------------------------------------------------------
// Stack pop sequence checker package
// Widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package spsc_pkg;

  localparam int VALUE_W         = 11;
  localparam int CFG_IDX_W       = 1;
  localparam int DEF_MAX_ENTRIES = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_STACK_CAPACITY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_LENGTH = 1'b1;

  localparam logic [VALUE_W-1:0] CAPACITY_RESET = 11'd1024;
  localparam logic [VALUE_W-1:0] LENGTH_RESET   = 11'd1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PUSH,
    ST_REFILL,
    ST_DONE
  } state_t;

endpackage

FILE: design/stack_pop_sequence_checker.sv
// After accept a pop passes through EVAL and then DONE, with REFILL between them when
// a new top is read back from the stack memory; a push run adds PUSH, which writes one
// value per cycle below the popped one, as the single stack memory write port allows.
// No new pop value is taken outside IDLE; pushes over a sequence total at most its length.
// Reset clears the sequencer, counters and registers; stack contents are not cleared.
// ----------------------------------------------------------------------------
// Stack pop sequence checker
// Checks a candidate pop order against pushes of 1..length on a bounded stack.
// ----------------------------------------------------------------------------
`include "stack_pop_sequence_checker_defines.svh"

module stack_pop_sequence_checker #(
  parameter int MAX_ENTRIES = spsc_pkg::DEF_MAX_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [spsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spsc_pkg::VALUE_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [spsc_pkg::VALUE_W-1:0]   pop_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           sequence_valid
);
  import spsc_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int PW = $clog2(MAX_ENTRIES + 1);

  logic [VALUE_W-1:0] stack_capacity;
  logic [VALUE_W-1:0] sequence_length;
  logic               res_valid;
  logic               res_value;
  logic               res_ready;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_capacity  <= CAPACITY_RESET;
      sequence_length <= LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STACK_CAPACITY:  stack_capacity  <= cfg_data;
        REG_SEQUENCE_LENGTH: sequence_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      sequence_valid <= res_value;
    end
  end

  spsc_core #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .AW         (AW),
    .PW         (PW)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pop_value      (pop_value),
    .stack_capacity (stack_capacity),
    .sequence_length(sequence_length),
    .res_valid      (res_valid),
    .res_value      (res_value),
    .res_ready      (res_ready),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

  spsc_ram #(
    .DEPTH(MAX_ENTRIES),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  `SPSC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `SPSC_ASSERT_NEXT(a_verdict_held, res_valid && !res_ready, res_valid)
  `SPSC_ASSERT_SAME(a_no_accept_with_verdict, res_valid, in_stall)
  `SPSC_ASSERT_SAME(a_no_push_with_verdict, ram_we, !res_valid)

endmodule

FILE: design/spsc_ram.sv
// ----------------------------------------------------------------------------
// Stack pop sequence checker stack memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spsc_ram #(
  parameter int DEPTH = spsc_pkg::DEF_MAX_ENTRIES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [spsc_pkg::VALUE_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [spsc_pkg::VALUE_W-1:0] rdata
);
  import spsc_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/spsc_core.sv
// ----------------------------------------------------------------------------
// Stack pop sequence checker sequencer
// Pops, pushes runs one entry a cycle, refills the top and counts items.
// ----------------------------------------------------------------------------
module spsc_core #(
  parameter int MAX_ENTRIES = spsc_pkg::DEF_MAX_ENTRIES,
  parameter int AW          = $clog2(MAX_ENTRIES),
  parameter int PW          = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [spsc_pkg::VALUE_W-1:0] pop_value,
  input  logic [spsc_pkg::VALUE_W-1:0] stack_capacity,
  input  logic [spsc_pkg::VALUE_W-1:0] sequence_length,
  output logic                         res_valid,
  output logic                         res_value,
  input  logic                         res_ready,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [spsc_pkg::VALUE_W-1:0] ram_wdata,
  output logic [AW-1:0]                ram_raddr,
  input  logic [spsc_pkg::VALUE_W-1:0] ram_rdata
);
  import spsc_pkg::*;

  localparam int NW = ((PW > VALUE_W) ? PW : VALUE_W) + 1;

  state_t             state, state_next;
  logic [PW-1:0]      sp, sp_next;
  logic [VALUE_W-1:0] pushed, pushed_next;
  logic [VALUE_W-1:0] items, items_next;
  logic               failed, failed_next;
  logic [VALUE_W-1:0] top, top_next;
  logic [VALUE_W-1:0] value, value_next;
  logic [VALUE_W-1:0] run, run_next;

  logic [NW-1:0]      cap_eff;
  logic [NW-1:0]      need;
  logic               last;

  assign cap_eff = (NW'(stack_capacity) > NW'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES)
                                                            : NW'(stack_capacity);
  assign need    = NW'(sp) + NW'(value - pushed);
  assign last    = ({1'b0, items} + (VALUE_W + 1)'(1)) >= {1'b0, sequence_length};

  assign in_stall  = (state != ST_IDLE);
  assign res_value = !failed && (sp == '0);
  assign ram_waddr = sp[AW-1:0];
  assign ram_wdata = run;
  assign ram_raddr = AW'(sp - PW'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      sp     <= '0;
      pushed <= '0;
      items  <= '0;
      failed <= 1'b0;
    end else begin
      state  <= state_next;
      sp     <= sp_next;
      pushed <= pushed_next;
      items  <= items_next;
      failed <= failed_next;
    end
    top   <= top_next;
    value <= value_next;
    run   <= run_next;
  end

  always_comb begin
    state_next  = state;
    sp_next     = sp;
    pushed_next = pushed;
    items_next  = items;
    failed_next = failed;
    top_next    = top;
    value_next  = value;
    run_next    = run;
    ram_we      = 1'b0;
    res_valid   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          value_next = pop_value;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = ST_DONE;
        if (!failed) begin
          if (sp != '0 && top == value) begin
            sp_next = sp - PW'(1);
            if (sp != PW'(1)) begin
              state_next = ST_REFILL;
            end
          end else if (value > pushed && value <= sequence_length) begin
            if (need > cap_eff) begin
              failed_next = 1'b1;
            end else if (pushed + VALUE_W'(1) == value) begin
              pushed_next = value;
            end else begin
              run_next   = pushed + VALUE_W'(1);
              state_next = ST_PUSH;
            end
          end else begin
            failed_next = 1'b1;
          end
        end
      end
      ST_PUSH: begin
        ram_we   = 1'b1;
        top_next = run;
        sp_next  = sp + PW'(1);
        run_next = run + VALUE_W'(1);
        if (run + VALUE_W'(1) == value) begin
          pushed_next = value;
          state_next  = ST_DONE;
        end
      end
      ST_REFILL: begin
        top_next   = ram_rdata;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (last) begin
          res_valid = 1'b1;
          if (res_ready) begin
            sp_next     = '0;
            pushed_next = '0;
            items_next  = '0;
            failed_next = 1'b0;
            state_next  = ST_IDLE;
          end
        end else begin
          items_next = items + VALUE_W'(1);
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: tb/sv/spsc_verdict_monitor.sv
// ----------------------------------------------------------------------------
// Stack pop order verdict monitor
// Watches the register port and both channels of the checker. It keeps its own
// copy of the stack and the sequence counters, predicts one verdict per
// completed pop order, and compares every accepted verdict with the oldest
// prediction.
// ----------------------------------------------------------------------------
module spsc_verdict_monitor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [spsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spsc_pkg::VALUE_W-1:0]   cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [spsc_pkg::VALUE_W-1:0]   pop_value,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           sequence_valid,
  output int                             mismatches,
  output int                             verdicts_pending,
  output int                             verdicts_checked
);
  import spsc_pkg::*;

  localparam int unsigned STACK_DEPTH = DEF_MAX_ENTRIES;

  logic [VALUE_W-1:0] stack_copy [STACK_DEPTH];
  int unsigned        stack_top;
  int unsigned        highest_pushed;
  int unsigned        values_seen;
  int unsigned        capacity;
  int unsigned        seq_length;
  bit                 order_broken;
  bit                 verdict_q [$];

  function automatic void restart_order();
    stack_top      = 0;
    highest_pushed = 0;
    values_seen    = 0;
    order_broken   = 1'b0;
  endfunction

  function automatic void take_pop(input int unsigned value);
    int unsigned room;
    int unsigned x;
    room = (capacity > STACK_DEPTH) ? STACK_DEPTH : capacity;
    if (stack_top > 0 && stack_copy[stack_top - 1] == value) begin
      stack_top--;
      return;
    end
    if (value > highest_pushed && value <= seq_length) begin
      if (stack_top + (value - highest_pushed) > room) begin
        order_broken = 1'b1;
        return;
      end
      for (x = highest_pushed + 1; x <= value; x++) begin
        stack_copy[stack_top] = VALUE_W'(x);
        stack_top++;
      end
      highest_pushed = value;
      stack_top--;
      return;
    end
    order_broken = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      capacity         = CAPACITY_RESET;
      seq_length       = LENGTH_RESET;
      mismatches       = 0;
      verdicts_checked = 0;
      restart_order();
      verdict_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict beat, expected none, got sequence_valid=%0b",
                   $time, sequence_valid);
          mismatches++;
        end else begin
          if (sequence_valid !== verdict_q[0]) begin
            $display("%0t: sequence_valid expected %0b, got %0b",
                     $time, verdict_q[0], sequence_valid);
            mismatches++;
          end
          void'(verdict_q.pop_front());
          verdicts_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        if (!order_broken)
          take_pop(pop_value);
        if (values_seen + 1 >= seq_length) begin
          verdict_q.push_back(!order_broken && stack_top == 0);
          restart_order();
        end else begin
          values_seen = (values_seen + 1) & 32'h7FF;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_STACK_CAPACITY:  capacity = cfg_data;
          REG_SEQUENCE_LENGTH: seq_length = cfg_data;
          default: ;
        endcase
      end
    end
    verdicts_pending = verdict_q.size();
  end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Stack pop sequence checker testbench
// Drives directed and random pop orders through the checker under several
// capacity and length settings, with bursty input and a stalling receiver,
// including one long receiver hold-off. A separate monitor predicts and
// compares the verdicts; this module gives the final result.
// ----------------------------------------------------------------------------
module tb;
  import spsc_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_CYCLES  = DEF_MAX_ENTRIES + 76;
  localparam int RANDOM_ITEMS  = 700;
  localparam int LONG_HOLD     = 400;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_STACK_CAPACITY;
  logic [VALUE_W-1:0]   cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [VALUE_W-1:0]   pop_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 sequence_valid;

  int                   mismatches;
  int                   verdicts_pending;
  int                   verdicts_checked;
  int                   cycle_count      = 0;
  int                   values_offered   = 0;
  int                   settings_written = 0;
  bit                   hold_armed       = 1'b0;
  logic [VALUE_W-1:0]   value_q [$];

  always #10 clk = ~clk;

  stack_pop_sequence_checker uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pop_value      (pop_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sequence_valid (sequence_valid)
  );

  spsc_verdict_monitor verdict_mon (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .pop_value        (pop_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .sequence_valid   (sequence_valid),
    .mismatches       (mismatches),
    .verdicts_pending (verdicts_pending),
    .verdicts_checked (verdicts_checked)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : receiver
    int seg_len;
    int seg_mode;
    @(posedge clk);
    forever begin
      if (hold_armed) begin
        hold_armed = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      seg_mode = $urandom_range(0, 2);
      seg_len  = $urandom_range(5, 60);
      repeat (seg_len) begin
        case (seg_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic offer_values();
    int burst;
    int gap;
    while (value_q.size() > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && value_q.size() > 0) begin
        in_valid  <= 1'b1;
        pop_value <= value_q.pop_front();
        @(posedge clk);
        while (in_stall) @(posedge clk);
        values_offered++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0 && value_q.size() > 0) begin
        in_valid  <= 1'b0;
        pop_value <= VALUE_W'($urandom_range(0, DEF_MAX_ENTRIES));
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic apply_settings(input int unsigned cap, input int unsigned len);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STACK_CAPACITY;
    cfg_data  <= VALUE_W'(cap);
    @(posedge clk);
    cfg_index <= REG_SEQUENCE_LENGTH;
    cfg_data  <= VALUE_W'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  // build an achievable order, then sometimes break it
  function automatic void add_pop_order(input int unsigned len);
    int unsigned held [$];
    int unsigned order [$];
    int unsigned next_push;
    int unsigned a;
    int unsigned b;
    int unsigned tmp;
    next_push = 1;
    while (order.size() < len) begin
      if (held.size() > 0 && (next_push > len || $urandom_range(0, 1) == 1)) begin
        order.push_back(held.pop_back());
      end else begin
        held.push_back(next_push);
        next_push++;
      end
    end
    a = $urandom_range(0, len - 1);
    b = $urandom_range(0, len - 1);
    case ($urandom_range(0, 9))
      7: begin
        tmp      = order[a];
        order[a] = order[b];
        order[b] = tmp;
      end
      8: order[a] = $urandom_range(0, 1) ? 0 : $urandom_range(len + 1, DEF_MAX_ENTRIES);
      9: foreach (order[i]) order[i] = $urandom_range(0, len + 1);
      default: ;
    endcase
    foreach (order[i]) value_q.push_back(VALUE_W'(order[i]));
  endfunction

  initial begin : stimulus
    int unsigned len_pick;
    int unsigned cap_pick;
    int unsigned eff_len;
    int unsigned phase_items;
    int unsigned phase_goal;
    int          random_total;
    bit          first;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // full-depth push under reset settings, then shorten the sequence under it
    value_q = '{1024, 1023, 1022};
    offer_values();
    apply_settings(1024, 3);
    value_q = '{1021};
    offer_values();

    apply_settings(2047, 4);
    value_q = '{4, 3, 2, 1};
    offer_values();

    apply_settings(0, 0);
    value_q = '{1};
    offer_values();

    apply_settings(1, 0);
    value_q = '{1};
    offer_values();

    apply_settings(2, 3);
    value_q = '{1, 3, 2, 3, 2, 1, 1, 1, 2, 4, 1, 2, 0, 1, 2};
    offer_values();

    random_total = 0;
    first        = 1'b1;
    while (random_total < RANDOM_ITEMS) begin
      if (first) begin
        len_pick = 1;
        cap_pick = 1;
      end else begin
        case ($urandom_range(0, 9))
          0: len_pick = 0;
          1: len_pick = 1;
          7, 8: len_pick = $urandom_range(9, 20);
          9: len_pick = $urandom_range(21, 64);
          default: len_pick = $urandom_range(2, 8);
        endcase
        eff_len = (len_pick == 0) ? 1 : len_pick;
        case ($urandom_range(0, 11))
          0: cap_pick = 0;
          1: cap_pick = 1;
          2: cap_pick = 2047;
          3: cap_pick = DEF_MAX_ENTRIES;
          default: cap_pick = $urandom_range(1, eff_len);
        endcase
      end
      apply_settings(cap_pick, len_pick);
      eff_len     = (len_pick == 0) ? 1 : len_pick;
      phase_goal  = first ? 100 : 60;
      phase_items = 0;
      while (phase_items < phase_goal) begin
        add_pop_order(eff_len);
        phase_items += eff_len;
      end
      // add one or two stray values, which can leave a sequence open across the next register change
      if (!first && $urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 2)) value_q.push_back(VALUE_W'($urandom_range(1, eff_len)));
      random_total += value_q.size();
      if (first)
        hold_armed = 1'b1;
      offer_values();
      first = 1'b0;
    end

    while (verdicts_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d pop values over %0d register settings plus reset defaults",
             values_offered, settings_written);
    $display("compared %0d verdicts, %0d mismatches", verdicts_checked, mismatches);
    if (mismatches == 0 && verdicts_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
